>>> rtl/kiss_frame_decoder_crc_macros.svh
// Assertion macros for the KISS frame decoder.
`ifndef KISS_FRAME_DECODER_CRC_MACROS_SVH
`define KISS_FRAME_DECODER_CRC_MACROS_SVH
`ifndef SYNTHESIS
`define KFD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define KFD_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define KFD_ASSERT(label, clk, rst, prop, msg)
`define KFD_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

>>> rtl/kfd_pkg.sv
package kfd_pkg;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_TYPE  = 2'd1,
    PH_DATA  = 2'd2,
    PH_ESC   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    K_DATA    = 3'd0,
    K_GOOD    = 3'd1,
    K_CRCERR  = 3'd2,
    K_ESCERR  = 3'd3,
    K_TOOLONG = 3'd4,
    K_START   = 3'd5
  } kind_t;

  localparam logic [1:0] MODE_SMACK = 2'd1;
  localparam logic [1:0] MODE_RMNC  = 2'd2;

  localparam logic [7:0] FEND  = 8'hC0;
  localparam logic [7:0] FESC  = 8'hDB;
  localparam logic [7:0] TFEND = 8'hDC;
  localparam logic [7:0] TFESC = 8'hDD;

  localparam logic [15:0] RMNC_INIT    = 16'hFFFF;
  localparam logic [7:0]  SMACK_SEED   = 8'h80;
  localparam logic [7:0]  RMNC_SEED    = 8'h20;
  localparam logic [15:0] RMNC_RESIDUE = 16'h7070;

  localparam logic [15:0] RMNC_TAB [256] = '{
    16'h0f87, 16'h1e0e, 16'h2c95, 16'h3d1c, 16'h49a3, 16'h582a, 16'h6ab1, 16'h7b38,
    16'h83cf, 16'h9246, 16'ha0dd, 16'hb154, 16'hc5eb, 16'hd462, 16'he6f9, 16'hf770,
    16'h1f06, 16'h0e8f, 16'h3c14, 16'h2d9d, 16'h5922, 16'h48ab, 16'h7a30, 16'h6bb9,
    16'h934e, 16'h82c7, 16'hb05c, 16'ha1d5, 16'hd56a, 16'hc4e3, 16'hf678, 16'he7f1,
    16'h2e85, 16'h3f0c, 16'h0d97, 16'h1c1e, 16'h68a1, 16'h7928, 16'h4bb3, 16'h5a3a,
    16'ha2cd, 16'hb344, 16'h81df, 16'h9056, 16'he4e9, 16'hf560, 16'hc7fb, 16'hd672,
    16'h3e04, 16'h2f8d, 16'h1d16, 16'h0c9f, 16'h7820, 16'h69a9, 16'h5b32, 16'h4abb,
    16'hb24c, 16'ha3c5, 16'h915e, 16'h80d7, 16'hf468, 16'he5e1, 16'hd77a, 16'hc6f3,
    16'h4d83, 16'h5c0a, 16'h6e91, 16'h7f18, 16'h0ba7, 16'h1a2e, 16'h28b5, 16'h393c,
    16'hc1cb, 16'hd042, 16'he2d9, 16'hf350, 16'h87ef, 16'h9666, 16'ha4fd, 16'hb574,
    16'h5d02, 16'h4c8b, 16'h7e10, 16'h6f99, 16'h1b26, 16'h0aaf, 16'h3834, 16'h29bd,
    16'hd14a, 16'hc0c3, 16'hf258, 16'he3d1, 16'h976e, 16'h86e7, 16'hb47c, 16'ha5f5,
    16'h6c81, 16'h7d08, 16'h4f93, 16'h5e1a, 16'h2aa5, 16'h3b2c, 16'h09b7, 16'h183e,
    16'he0c9, 16'hf140, 16'hc3db, 16'hd252, 16'ha6ed, 16'hb764, 16'h85ff, 16'h9476,
    16'h7c00, 16'h6d89, 16'h5f12, 16'h4e9b, 16'h3a24, 16'h2bad, 16'h1936, 16'h08bf,
    16'hf048, 16'he1c1, 16'hd35a, 16'hc2d3, 16'hb66c, 16'ha7e5, 16'h957e, 16'h84f7,
    16'h8b8f, 16'h9a06, 16'ha89d, 16'hb914, 16'hcdab, 16'hdc22, 16'heeb9, 16'hff30,
    16'h07c7, 16'h164e, 16'h24d5, 16'h355c, 16'h41e3, 16'h506a, 16'h62f1, 16'h7378,
    16'h9b0e, 16'h8a87, 16'hb81c, 16'ha995, 16'hdd2a, 16'hcca3, 16'hfe38, 16'hefb1,
    16'h1746, 16'h06cf, 16'h3454, 16'h25dd, 16'h5162, 16'h40eb, 16'h7270, 16'h63f9,
    16'haa8d, 16'hbb04, 16'h899f, 16'h9816, 16'heca9, 16'hfd20, 16'hcfbb, 16'hde32,
    16'h26c5, 16'h374c, 16'h05d7, 16'h145e, 16'h60e1, 16'h7168, 16'h43f3, 16'h527a,
    16'hba0c, 16'hab85, 16'h991e, 16'h8897, 16'hfc28, 16'heda1, 16'hdf3a, 16'hceb3,
    16'h3644, 16'h27cd, 16'h1556, 16'h04df, 16'h7060, 16'h61e9, 16'h5372, 16'h42fb,
    16'hc98b, 16'hd802, 16'hea99, 16'hfb10, 16'h8faf, 16'h9e26, 16'hacbd, 16'hbd34,
    16'h45c3, 16'h544a, 16'h66d1, 16'h7758, 16'h03e7, 16'h126e, 16'h20f5, 16'h317c,
    16'hd90a, 16'hc883, 16'hfa18, 16'heb91, 16'h9f2e, 16'h8ea7, 16'hbc3c, 16'hadb5,
    16'h5542, 16'h44cb, 16'h7650, 16'h67d9, 16'h1366, 16'h02ef, 16'h3074, 16'h21fd,
    16'he889, 16'hf900, 16'hcb9b, 16'hda12, 16'haead, 16'hbf24, 16'h8dbf, 16'h9c36,
    16'h64c1, 16'h7548, 16'h47d3, 16'h565a, 16'h22e5, 16'h336c, 16'h01f7, 16'h107e,
    16'hf808, 16'he981, 16'hdb1a, 16'hca93, 16'hbe2c, 16'hafa5, 16'h9d3e, 16'h8cb7,
    16'h7440, 16'h65c9, 16'h5752, 16'h46db, 16'h3264, 16'h23ed, 16'h1176, 16'h00ff
  };

  function automatic logic [15:0] smack_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    logic [15:0] r;
    t = crc[7:0] ^ b;
    r = {8'd0, t};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    end
    return {8'd0, crc[15:8]} ^ r;
  endfunction

  function automatic logic [15:0] rmnc_feed(input logic [15:0] crc, input logic [7:0] b);
    return {crc[7:0], 8'd0} ^ RMNC_TAB[crc[15:8] ^ b];
  endfunction

endpackage

>>> rtl/kiss_frame_decoder_crc.sv
// KISS receive deframer with optional CRC check. Raw serial bytes enter on
// the in_* channel; each word is decoded in one pass and yields at most one
// result word: an unescaped data byte, a frame start, a good frame, a CRC
// error, an escape error or an overlong frame. A new byte is taken every
// cycle while the result register is empty or being drained, so throughput
// is one byte per clock. crc_mode selects no check, SMACK CRC-16 or RMNC
// CRC; the user must write it only while the block is idle, and the block
// does not enforce this. Frames longer than MAX_FRAME_BYTES are abandoned.
module kiss_frame_decoder_crc #(
  parameter int MAX_FRAME_BYTES = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] result_kind,
  output logic [7:0] data_byte,
  output logic [9:0] frame_length,
  output logic       dropped_previous,
  output logic       receiving,
  output logic [15:0] crc_error_total,
  output logic [15:0] escape_error_total
);
  import kfd_pkg::*;
`include "kiss_frame_decoder_crc_macros.svh"

  // Count register wide enough to hold MAX_FRAME_BYTES + 1.
  localparam int CW = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME_BYTES);

  logic [1:0]   crc_mode;
  phase_t       rx_phase, rx_phase_next;
  logic [15:0]  crc_acc, crc_acc_next;
  logic         frame_open, frame_open_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [15:0]  crc_err_cnt, crc_err_cnt_next;
  logic [15:0]  esc_err_cnt, esc_err_cnt_next;

  logic       emit;
  kind_t      kind;
  logic [7:0] data_v;
  logic [CW-1:0] len_v;
  logic       dropped_v;
  logic       accept;

  // The result register is free when empty or being taken this cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic       payload;
    logic       bad;
    logic [7:0] b;
    logic [CW-1:0] cnt_inc;
    rx_phase_next    = rx_phase;
    crc_acc_next     = crc_acc;
    frame_open_next  = frame_open;
    byte_count_next  = byte_count;
    crc_err_cnt_next = crc_err_cnt;
    esc_err_cnt_next = esc_err_cnt;
    emit      = 1'b0;
    kind      = K_DATA;
    data_v    = 8'd0;
    len_v     = '0;
    dropped_v = 1'b0;
    payload   = 1'b0;
    bad       = 1'b0;
    b         = rx_byte;
    cnt_inc   = byte_count + CW'(1);
    unique case (rx_phase)
      PH_WAIT: begin
        if (rx_byte == FEND) rx_phase_next = PH_TYPE;
      end
      PH_TYPE: begin
        if (rx_byte != FEND) begin
          if (rx_byte[3:0] != 4'd0) begin
            rx_phase_next = PH_WAIT;
          end else begin
            rx_phase_next   = PH_DATA;
            dropped_v       = frame_open;
            frame_open_next = 1'b1;
            byte_count_next = '0;
            if (crc_mode == MODE_SMACK) crc_acc_next = smack_feed(16'd0, SMACK_SEED);
            else if (crc_mode == MODE_RMNC) crc_acc_next = rmnc_feed(RMNC_INIT, RMNC_SEED);
            kind = K_START;
            emit = 1'b1;
          end
        end
      end
      PH_DATA: begin
        if (rx_byte == FEND) begin
          rx_phase_next = PH_WAIT;
          if (frame_open) begin
            len_v = byte_count;
            if (crc_mode == MODE_SMACK || crc_mode == MODE_RMNC) begin
              if (byte_count > CW'(2)) len_v = byte_count - CW'(2);
              bad = (crc_mode == MODE_SMACK) ? (crc_acc != 16'd0)
                                             : (crc_acc != RMNC_RESIDUE);
            end
            byte_count_next = len_v;
            emit = 1'b1;
            if (bad) begin
              crc_err_cnt_next = crc_err_cnt + 16'd1;
              kind = K_CRCERR;
            end else begin
              frame_open_next = 1'b0;
              kind = K_GOOD;
            end
          end
        end else if (rx_byte == FESC) begin
          rx_phase_next = PH_ESC;
        end else begin
          payload = 1'b1;
        end
      end
      PH_ESC: begin
        if (rx_byte == TFEND) begin
          b = FEND;
          rx_phase_next = PH_DATA;
          payload = 1'b1;
        end else if (rx_byte == TFESC) begin
          b = FESC;
          rx_phase_next = PH_DATA;
          payload = 1'b1;
        end else begin
          esc_err_cnt_next = esc_err_cnt + 16'd1;
          rx_phase_next = PH_WAIT;
          kind = K_ESCERR;
          emit = 1'b1;
        end
      end
      default: ;
    endcase
    if (payload) begin
      if (crc_mode == MODE_SMACK) crc_acc_next = smack_feed(crc_acc, b);
      else if (crc_mode == MODE_RMNC) crc_acc_next = rmnc_feed(crc_acc, b);
      byte_count_next = cnt_inc;
      emit = 1'b1;
      if (cnt_inc > MAX_CNT) begin
        rx_phase_next = PH_WAIT;
        kind = K_TOOLONG;
      end else begin
        kind   = K_DATA;
        data_v = b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode    <= 2'd0;
      rx_phase    <= PH_WAIT;
      crc_acc     <= 16'd0;
      frame_open  <= 1'b0;
      byte_count  <= '0;
      crc_err_cnt <= 16'd0;
      esc_err_cnt <= 16'd0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) crc_mode <= cfg_data;
      if (accept) begin
        rx_phase    <= rx_phase_next;
        crc_acc     <= crc_acc_next;
        frame_open  <= frame_open_next;
        byte_count  <= byte_count_next;
        crc_err_cnt <= crc_err_cnt_next;
        esc_err_cnt <= esc_err_cnt_next;
        out_valid   <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload register; loaded only with an accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      result_kind        <= kind;
      data_byte          <= data_v;
      frame_length       <= 10'(len_v);
      dropped_previous   <= dropped_v;
      receiving          <= rx_phase_next[1];
      crc_error_total    <= crc_err_cnt_next;
      escape_error_total <= esc_err_cnt_next;
    end
  end

  `KFD_ASSERT(a_stall_holds, clk, rst, (out_valid && !out_ready) |=> out_valid, "result lost")
  `KFD_ASSERT(a_no_accept_stalled, clk, rst, (out_valid && !out_ready) |-> !in_ready, "overrun")
  `KFD_ASSERT(a_count_bound, clk, rst, byte_count <= MAX_CNT + CW'(1), "count overflow")
  `KFD_ASSERT(a_data_in_frame, clk, rst, (out_valid && result_kind == K_DATA) |-> frame_open, "data outside frame")

endmodule
